### hdl/convolutional_interleaver_macros.svh
// Assertion helpers for the interleaver. Both expect clk and arst_n in scope.
`ifndef CONVOLUTIONAL_INTERLEAVER_MACROS_SVH
`define CONVOLUTIONAL_INTERLEAVER_MACROS_SVH

`ifndef SYNTHESIS
`define CVI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CVI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CVI_ASSERT(lbl, prop, msg)
`define CVI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/cvi_pkg.sv
package cvi_pkg;

	localparam int RING_DEPTH_DEF  = 32768;
	localparam int SYMBOL_BITS_DEF = 8;
	localparam int ROWS            = 32;
	localparam int ROW_BITS        = 5;
	localparam int STEP_W          = 7;
	localparam int RLEN_W          = 16;
	localparam int CLAMP_W         = 17;
	localparam int RED_STEPS       = 13;
	localparam int APB_AW          = 4;
	localparam int APB_DW          = 32;
	localparam int OUT_FIFO_DEPTH  = 8;

	localparam logic [1:0] REG_ENABLE   = 2'd0;
	localparam logic [1:0] REG_ROW_STEP = 2'd1;
	localparam logic [1:0] REG_RING_LEN = 2'd2;

	localparam logic [ROW_BITS-1:0] ROW_PERM [ROWS] = '{
		5'd0,  5'd9,  5'd18, 5'd27, 5'd4,  5'd13, 5'd22, 5'd31,
		5'd8,  5'd17, 5'd26, 5'd3,  5'd12, 5'd21, 5'd30, 5'd7,
		5'd16, 5'd25, 5'd2,  5'd11, 5'd20, 5'd29, 5'd6,  5'd15,
		5'd24, 5'd1,  5'd10, 5'd19, 5'd28, 5'd5,  5'd14, 5'd23
	};

	typedef struct packed {
		logic                busy;
		logic                wr_en;
		logic [ROW_BITS-1:0] wr_row;
	} bld_status_t;

endpackage

### hdl/convolutional_interleaver.sv
// 32-row convolutional interleaver with an APB register port.
// Symbols enter on the s_axis channel (one per tdata beat) and leave on
// m_axis in the same count, one result per symbol. With enable low the
// symbol comes back unchanged and the internal state is held.
// Throughput: one symbol per cycle while s_axis_tready is high. Each symbol
// reads the two row pointer tables in one stage and then writes and reads
// the ring in the next; the per-frame pointer decrement is a single shared
// offset. From stage 3 each result is pushed into the output queue, and
// m_axis_tvalid is high while that queue holds a result. The 8-entry queue
// decouples the sides: while m_axis_tready is low the pipeline drains into
// it, and s_axis_tready drops once queued plus in-flight results would fill
// it; nothing is lost or dropped. Reset and every write to the enable,
// row_step or ring_length register restart the block: the ring is swept to
// zero while the row pointers are rebuilt in parallel, and s_axis_tready
// stays low until both are done. Register writes are accepted at any time.
// Registers: 0x0 enable, 0x4 row_step, 0x8 ring_length (clamped to
// 1..RING_DEPTH).
`include "convolutional_interleaver_macros.svh"

module convolutional_interleaver #(
	parameter int RING_DEPTH  = cvi_pkg::RING_DEPTH_DEF,
	parameter int SYMBOL_BITS = cvi_pkg::SYMBOL_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [((SYMBOL_BITS + 7) / 8)*8-1:0] s_axis_tdata,  // symbol_in
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [((SYMBOL_BITS + 7) / 8)*8-1:0] m_axis_tdata,  // symbol_out
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [cvi_pkg::APB_AW-1:0]           paddr,
	input  logic [cvi_pkg::APB_DW-1:0]           pwdata,
	output logic [cvi_pkg::APB_DW-1:0]           prdata,
	output logic                                 pready
);
	import cvi_pkg::*;

	localparam int AW      = $clog2(RING_DEPTH);
	localparam int LW      = AW + 1;
	localparam int TDATA_W = ((SYMBOL_BITS + 7) / 8) * 8;
	localparam int FAW     = $clog2(OUT_FIFO_DEPTH);
	localparam int CNT_W   = FAW + 2;

	// configuration
	logic                enable_q;
	logic [STEP_W-1:0]   row_step_q;
	logic [RLEN_W-1:0]   ring_length_q;
	logic                restart_q;
	logic                cfg_wr;
	logic [1:0]          cfg_idx;
	logic [CLAMP_W-1:0]  rl_ext;
	logic [CLAMP_W-1:0]  rl_eff;
	logic [LW-1:0]       ring_len;

	// restart machinery
	logic                clr_act_q;
	logic [AW:0]         clr_q;
	bld_status_t         bld_stat;
	logic [AW-1:0]       bld_wbase;
	logic [AW-1:0]       bld_rbase;
	logic                busy;

	// datapath
	logic                in_acc;
	logic [ROW_BITS-1:0] row_q;
	logic [AW-1:0]       f_q;
	logic                v_s1, v_s2, v_s3;
	logic [SYMBOL_BITS-1:0] sym_s1, sym_s2, sym_s3;
	logic [AW-1:0]       f_s1;
	logic                byp_s1, byp_s2;
	logic [AW-1:0]       wa_s2, ra_s2;
	logic                fwd_s3;
	logic [AW-1:0]       wtab_rdata, rtab_rdata;
	logic [AW-1:0]       wa, ra;
	logic                ring_we;
	logic [AW-1:0]       ring_waddr;
	logic [SYMBOL_BITS-1:0] ring_wdata;
	logic [SYMBOL_BITS-1:0] ring_rdata;
	logic [SYMBOL_BITS-1:0] result;

	// output queue
	logic [SYMBOL_BITS-1:0] fifo_q [OUT_FIFO_DEPTH];
	logic [FAW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    inflight;
	logic                push, pop;

	function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] base,
		input logic [AW-1:0] ofs, input logic [LW-1:0] len);
		logic [LW-1:0] d;
		d = LW'(base) - LW'(ofs);
		if (base < ofs) begin
			d = d + len;
		end
		return d[AW-1:0];
	endfunction

	// ---------------- register port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			row_step_q    <= STEP_W'(4);
			ring_length_q <= RLEN_W'(2016);
			restart_q     <= 1'b1;
		end else begin
			restart_q <= cfg_wr && (cfg_idx inside {REG_ENABLE, REG_ROW_STEP, REG_RING_LEN});
			if (cfg_wr) begin
				case (cfg_idx)
					REG_ENABLE:   enable_q      <= pwdata[0];
					REG_ROW_STEP: row_step_q    <= pwdata[STEP_W-1:0];
					REG_RING_LEN: ring_length_q <= pwdata[RLEN_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ENABLE:   prdata = APB_DW'(enable_q);
			REG_ROW_STEP: prdata = APB_DW'(row_step_q);
			REG_RING_LEN: prdata = APB_DW'(ring_length_q);
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		rl_ext = CLAMP_W'(ring_length_q);
		if (rl_ext == '0) begin
			rl_eff = CLAMP_W'(1);
		end else if (rl_ext > CLAMP_W'(RING_DEPTH)) begin
			rl_eff = CLAMP_W'(RING_DEPTH);
		end else begin
			rl_eff = rl_ext;
		end
		ring_len = rl_eff[LW-1:0];
	end

	// ---------------- restart: ring sweep and pointer rebuild ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_act_q <= 1'b0;
			clr_q     <= '0;
		end else if (restart_q) begin
			clr_act_q <= 1'b1;
			clr_q     <= '0;
		end else if (clr_act_q) begin
			clr_q <= clr_q + (AW+1)'(1);
			if (clr_q == (AW+1)'(RING_DEPTH - 1)) begin
				clr_act_q <= 1'b0;
			end
		end
	end

	cvi_ptr_build #(
		.RING_DEPTH (RING_DEPTH)
	) u_build (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (restart_q),
		.row_step (row_step_q),
		.ring_len (ring_len),
		.status   (bld_stat),
		.wbase    (bld_wbase),
		.rbase    (bld_rbase)
	);

	assign busy = restart_q || clr_act_q || bld_stat.busy;

	// ---------------- input side ----------------
	assign inflight      = CNT_W'(v_s1) + CNT_W'(v_s2) + CNT_W'(v_s3);
	assign s_axis_tready = !busy && ((cnt_q + inflight) < CNT_W'(OUT_FIFO_DEPTH));
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// row counter and shared frame offset; pointers are base minus offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			f_q   <= '0;
		end else if (restart_q) begin
			row_q <= '0;
			f_q   <= '0;
		end else if (in_acc && enable_q) begin
			row_q <= row_q + ROW_BITS'(1);
			if (row_q == ROW_BITS'(ROWS - 1)) begin
				f_q <= ((LW'(f_q) + LW'(1)) == ring_len) ? '0 : f_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: row pointer tables
	cvi_ram #(
		.WIDTH (AW),
		.DEPTH (ROWS)
	) u_wtab (
		.clk   (clk),
		.we    (bld_stat.wr_en),
		.waddr (bld_stat.wr_row),
		.wdata (bld_wbase),
		.raddr (ROW_PERM[row_q]),
		.rdata (wtab_rdata)
	);

	cvi_ram #(
		.WIDTH (AW),
		.DEPTH (ROWS)
	) u_rtab (
		.clk   (clk),
		.we    (bld_stat.wr_en),
		.waddr (bld_stat.wr_row),
		.wdata (bld_rbase),
		.raddr (row_q),
		.rdata (rtab_rdata)
	);

	assign wa = ring_sub(wtab_rdata, f_s1, ring_len);
	assign ra = ring_sub(rtab_rdata, f_s1, ring_len);

	always_ff @(posedge clk) begin
		sym_s1 <= s_axis_tdata[SYMBOL_BITS-1:0];
		f_s1   <= f_q;
		byp_s1 <= !enable_q;
		sym_s2 <= sym_s1;
		byp_s2 <= byp_s1;
		wa_s2  <= wa;
		ra_s2  <= ra;
		sym_s3 <= sym_s2;
		// bypass, or same entry written and read: take the new symbol
		fwd_s3 <= byp_s2 || (ra_s2 == wa_s2);
	end

	// stage 2: ring access, sweep has the port during restart
	assign ring_we    = clr_act_q || (v_s2 && !byp_s2);
	assign ring_waddr = clr_act_q ? clr_q[AW-1:0] : wa_s2;
	assign ring_wdata = clr_act_q ? '0 : sym_s2;

	cvi_ram #(
		.WIDTH (SYMBOL_BITS),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.raddr (ra_s2),
		.rdata (ring_rdata)
	);

	// stage 3: result into the output queue
	assign result = fwd_s3 ? sym_s3 : ring_rdata;
	assign push   = v_s3;
	assign pop    = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FAW'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= result;
		end
	end

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = TDATA_W'(fifo_q[rd_ptr_q]);

	`CVI_ASSERT(a_queue_credit, (cnt_q + inflight) <= CNT_W'(OUT_FIFO_DEPTH), "output queue overrun")
	`CVI_ASSERT(a_waddr_range, v_s2 && !byp_s2 |-> LW'(wa_s2) < ring_len, "write address beyond length")
	`CVI_ASSERT(a_raddr_range, v_s2 && !byp_s2 |-> LW'(ra_s2) < ring_len, "read address beyond length")
	`CVI_ASSERT(a_offset_range, !busy |-> (LW'(f_q) < ring_len), "frame offset beyond length")
	`CVI_ASSERT_NEXT(a_restart_build, restart_q, bld_stat.busy, "pointer rebuild did not start")

endmodule

### hdl/cvi_ram.sv
module cvi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/cvi_ptr_build.sv
module cvi_ptr_build #(
	parameter int RING_DEPTH = cvi_pkg::RING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cvi_pkg::STEP_W-1:0]     row_step,
	input  logic [$clog2(RING_DEPTH):0]    ring_len,
	output cvi_pkg::bld_status_t           status,
	output logic [$clog2(RING_DEPTH)-1:0]  wbase,
	output logic [$clog2(RING_DEPTH)-1:0]  rbase
);
	import cvi_pkg::*;

	localparam int AW     = $clog2(RING_DEPTH);
	localparam int LW     = AW + 1;
	localparam int ACCW   = LW + RED_STEPS;
	localparam int JW     = $clog2(RED_STEPS);
	localparam int PROD_W = STEP_W + ROW_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_RED  = 2'd2;

	logic [1:0]          state_q;
	logic [ROW_BITS-1:0] row_q;
	logic                phase_q;
	logic [JW-1:0]       j_q;
	logic [ACCW-1:0]     acc_q;
	logic [AW-1:0]       wcur_q;
	logic [AW-1:0]       wprev_q;

	logic [ROW_BITS-1:0] mult_n;
	logic [PROD_W-1:0]   prod;
	logic [ACCW-1:0]     load_val;
	logic [ACCW-1:0]     lsh;
	logic [ACCW-1:0]     red_val;
	logic                last_red;

	// row n: w = w(n-1) + 1 + step*(n-1), r = w + step*n, both reduced mod len
	always_comb begin
		mult_n = phase_q ? row_q : row_q - ROW_BITS'(1);
		prod   = PROD_W'(row_step) * PROD_W'(mult_n);
		if (phase_q) begin
			load_val = ACCW'(wcur_q) + ACCW'(prod);
		end else if (row_q == '0) begin
			load_val = '0;
		end else begin
			load_val = ACCW'(wprev_q) + ACCW'(prod) + ACCW'(1);
		end
		// restoring reduction, one shifted length per cycle
		lsh      = ACCW'(ring_len) << j_q;
		red_val  = (acc_q >= lsh) ? acc_q - lsh : acc_q;
		last_red = (state_q == ST_RED) && (j_q == '0);
	end

	assign status.busy   = (state_q != ST_IDLE);
	assign status.wr_en  = last_red && phase_q;
	assign status.wr_row = row_q;
	assign wbase         = wcur_q;
	assign rbase         = red_val[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			phase_q <= 1'b0;
			j_q     <= '0;
		end else if (start) begin
			state_q <= ST_LOAD;
			row_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					j_q     <= JW'(RED_STEPS - 1);
					state_q <= ST_RED;
				end
				ST_RED: begin
					j_q <= j_q - JW'(1);
					if (j_q == '0) begin
						if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= ST_LOAD;
						end else begin
							phase_q <= 1'b0;
							if (row_q == ROW_BITS'(ROWS - 1)) begin
								state_q <= ST_IDLE;
							end else begin
								row_q   <= row_q + ROW_BITS'(1);
								state_q <= ST_LOAD;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			acc_q <= load_val;
		end else if (state_q == ST_RED) begin
			acc_q <= red_val;
		end
		if (last_red && !phase_q) begin
			wcur_q <= red_val[AW-1:0];
		end
		if (last_red && phase_q) begin
			wprev_q <= wcur_q;
		end
	end

endmodule
